FILE: rtl/bres_pkg.sv
// Shared types and constants for the Bresenham line pixel generator.
package bres_pkg;

  localparam int DIM_W     = 13;
  localparam int ROWB_W    = 15;
  localparam int BPP_W     = 3;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd3;

  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH     = 13'd640;
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT    = 13'd480;
  localparam logic [ROWB_W-1:0] RST_ROW_BYTES       = 15'd1920;
  localparam logic [BPP_W-1:0]  RST_BYTES_PER_PIXEL = 3'd3;

  typedef enum logic [1:0] {
    ST_DRAW   = 2'd0,
    ST_SKIP   = 2'd1,
    ST_REJECT = 2'd2,
    ST_IDLE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_REJECT = 2'd1,
    CMD_STEP   = 2'd2
  } cmd_kind_t;

  localparam int KIND_W = 2;

  // point: a line point whose draw/skip status is settled downstream
  typedef struct packed {
    status_t status;
    logic    point;
    logic    last;
  } pt_ctl_t;

endpackage

FILE: rtl/bres_front.sv
// Front end: takes requests, checks line bounds and precomputes deltas.
module bres_front import bres_pkg::*; #(
  parameter int CW = 13,
  parameter int QW = KIND_W + 2 + 6 * CW
) (
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             mode,
  input  logic [CW-1:0]    start_x,
  input  logic [CW-1:0]    start_y,
  input  logic [CW-1:0]    end_x,
  input  logic [CW-1:0]    end_y,
  input  logic [DIM_W-1:0] image_width,
  input  logic [DIM_W-1:0] image_height,
  output logic             q_push,
  output logic [QW-1:0]    q_data,
  input  logic             q_full
);

  localparam int CMPW = (CW > DIM_W) ? CW : DIM_W;

  logic            reject;
  logic [CW-1:0]   dx, dy;
  logic            sxn, syn;
  cmd_kind_t       kind;

  always_comb begin
    reject = (CMPW'(start_x) > CMPW'(image_width))  ||
             (CMPW'(start_y) > CMPW'(image_height)) ||
             (CMPW'(end_x)   > CMPW'(image_width))  ||
             (CMPW'(end_y)   > CMPW'(image_height));
    dx  = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
    dy  = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
    sxn = !(start_x < end_x);
    syn = !(start_y < end_y);
    if (mode) begin
      kind = CMD_STEP;
    end else if (reject) begin
      kind = CMD_REJECT;
    end else begin
      kind = CMD_LOAD;
    end
  end

  assign q_data   = {kind, sxn, syn, dy, dx, end_y, end_x, start_y, start_x};
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

FILE: rtl/bres_queue.sv
// Two-entry request queue between front end and line walker.
module bres_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         not_empty
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full      = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign dout      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/bres_walk.sv
// Line walker: holds the Bresenham state and emits one result (a point or a status) per request.
module bres_walk import bres_pkg::*; #(
  parameter int CW = 13,
  parameter int QW = KIND_W + 2 + 6 * CW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  logic [QW-1:0] q_data,
  output logic          q_pop,
  input  logic          down_ready,
  output logic          p_valid,
  output pt_ctl_t       p_ctl,
  output logic [CW-1:0] p_x,
  output logic [CW-1:0] p_y
);

  localparam int EW = CW + 2;

  cmd_kind_t         kind;
  logic              c_sxn, c_syn;
  logic [CW-1:0]     c_dx, c_dy, c_x0, c_y0, c_x1, c_y1;

  logic              active, active_next;
  logic [CW-1:0]     cur_x, cur_y, goal_x, goal_y, delta_x, delta_y;
  logic [CW-1:0]     cur_x_next, cur_y_next, goal_x_next, goal_y_next;
  logic [CW-1:0]     delta_x_next, delta_y_next;
  logic              step_x_negative, step_y_negative;
  logic              step_x_negative_next, step_y_negative_next;
  logic signed [EW-1:0] error_term, error_term_next;

  logic signed [EW:0] e2, dx_s, dy_s;
  logic              move_x, move_y;
  logic [CW-1:0]     sx, sy;
  logic signed [EW-1:0] err_step;

  pt_ctl_t           ctl_next;
  logic [CW-1:0]     px_next, py_next;
  logic              p_ready;

  assign kind  = cmd_kind_t'(q_data[QW-1 -: KIND_W]);
  assign c_sxn = q_data[6*CW+1];
  assign c_syn = q_data[6*CW];
  assign c_dy  = q_data[5*CW +: CW];
  assign c_dx  = q_data[4*CW +: CW];
  assign c_y1  = q_data[3*CW +: CW];
  assign c_x1  = q_data[2*CW +: CW];
  assign c_y0  = q_data[CW +: CW];
  assign c_x0  = q_data[0 +: CW];

  assign p_ready = !p_valid || down_ready;
  assign q_pop   = q_valid && p_ready;

  // one Bresenham step from the current state
  always_comb begin
    e2     = {error_term, 1'b0};
    dx_s   = $signed((EW+1)'(delta_x));
    dy_s   = $signed((EW+1)'(delta_y));
    move_x = e2 > -dy_s;
    move_y = e2 < dx_s;
    err_step = error_term
             - (move_x ? $signed(EW'(delta_y)) : '0)
             + (move_y ? $signed(EW'(delta_x)) : '0);
    sx = move_x ? (step_x_negative ? cur_x - 1'b1 : cur_x + 1'b1) : cur_x;
    sy = move_y ? (step_y_negative ? cur_y - 1'b1 : cur_y + 1'b1) : cur_y;
  end

  always_comb begin
    active_next          = active;
    cur_x_next           = cur_x;
    cur_y_next           = cur_y;
    goal_x_next          = goal_x;
    goal_y_next          = goal_y;
    delta_x_next         = delta_x;
    delta_y_next         = delta_y;
    step_x_negative_next = step_x_negative;
    step_y_negative_next = step_y_negative;
    error_term_next      = error_term;
    ctl_next             = '{status: ST_IDLE, point: 1'b0, last: 1'b0};
    px_next              = '0;
    py_next              = '0;
    case (kind)
      CMD_LOAD: begin
        cur_x_next           = c_x0;
        cur_y_next           = c_y0;
        goal_x_next          = c_x1;
        goal_y_next          = c_y1;
        delta_x_next         = c_dx;
        delta_y_next         = c_dy;
        step_x_negative_next = c_sxn;
        step_y_negative_next = c_syn;
        error_term_next      = $signed(EW'(c_dx)) - $signed(EW'(c_dy));
        ctl_next.point       = 1'b1;
        ctl_next.status      = ST_DRAW;
        ctl_next.last        = (c_x0 == c_x1) && (c_y0 == c_y1);
        active_next          = !ctl_next.last;
        px_next              = c_x0;
        py_next              = c_y0;
      end
      CMD_REJECT: begin
        active_next     = 1'b0;
        ctl_next.status = ST_REJECT;
      end
      CMD_STEP: begin
        if (active) begin
          cur_x_next      = sx;
          cur_y_next      = sy;
          error_term_next = err_step;
          ctl_next.point  = 1'b1;
          ctl_next.status = ST_DRAW;
          ctl_next.last   = (sx == goal_x) && (sy == goal_y);
          active_next     = !ctl_next.last;
          px_next         = sx;
          py_next         = sy;
        end
      end
      default: begin
        ctl_next.status = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      p_valid <= 1'b0;
    end else if (p_ready) begin
      p_valid <= q_valid;
      if (q_valid) begin
        active <= active_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_x           <= cur_x_next;
      cur_y           <= cur_y_next;
      goal_x          <= goal_x_next;
      goal_y          <= goal_y_next;
      delta_x         <= delta_x_next;
      delta_y         <= delta_y_next;
      step_x_negative <= step_x_negative_next;
      step_y_negative <= step_y_negative_next;
      error_term      <= error_term_next;
      p_ctl           <= ctl_next;
      p_x             <= px_next;
      p_y             <= py_next;
    end
  end

endmodule

FILE: rtl/bres_addr.sv
// Address stages: bounds check, frame-buffer offset and output register.
module bres_addr import bres_pkg::*; #(
  parameter int CW = 13,
  parameter int OB = 26
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              p_valid,
  input  pt_ctl_t           p_ctl,
  input  logic [CW-1:0]     p_x,
  input  logic [CW-1:0]     p_y,
  output logic              m_ready,
  input  logic [DIM_W-1:0]  image_width,
  input  logic [DIM_W-1:0]  image_height,
  input  logic [ROWB_W-1:0] row_bytes,
  input  logic [BPP_W-1:0]  bytes_per_pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [OB-1:0]     pixel_offset,
  output logic [CW-1:0]     pixel_x,
  output logic [CW-1:0]     pixel_y,
  output logic              last
);

  localparam int CMPW = (CW > DIM_W) ? CW : DIM_W;
  localparam int PYW  = CW + ROWB_W;
  localparam int PXW  = CW + BPP_W;
  localparam int SUMW = PYW + 1;
  localparam int EXTW = (SUMW > OB) ? SUMW : OB;

  logic            o_ready;
  logic            m_valid;
  pt_ctl_t         m_ctl;
  logic [CW-1:0]   m_x, m_y;
  logic [PYW-1:0]  m_py;
  logic [PXW-1:0]  m_px;
  logic            m_outside;
  logic [EXTW-1:0] sum;

  assign o_ready = !out_valid || !out_stall;
  assign m_ready = !m_valid || o_ready;
  assign sum     = EXTW'(m_py) + EXTW'(m_px);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (m_ready) begin
        m_valid <= p_valid;
      end
      if (o_ready) begin
        out_valid <= m_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready) begin
      m_ctl     <= p_ctl;
      m_x       <= p_x;
      m_y       <= p_y;
      m_py      <= PYW'(p_y) * PYW'(row_bytes);
      m_px      <= PXW'(p_x) * PXW'(bytes_per_pixel);
      m_outside <= (CMPW'(p_x) >= CMPW'(image_width)) ||
                   (CMPW'(p_y) >= CMPW'(image_height));
    end
    if (o_ready) begin
      if (m_ctl.point) begin
        status <= m_outside ? ST_SKIP : ST_DRAW;
      end else begin
        status <= m_ctl.status;
      end
      pixel_offset <= (m_ctl.point && !m_outside) ? sum[OB-1:0] : '0;
      pixel_x      <= m_x;
      pixel_y      <= m_y;
      last         <= m_ctl.last;
    end
  end

endmodule

FILE: rtl/bresenham_line_pixel_generator.sv
// Bresenham line pixel generator. A mode 0 request loads a line's end points and returns
// its first point, or a rejected status if any coordinate exceeds the image size; each
// mode 1 request returns the next point of the line, flagged last at the end point, or
// an idle status when no line is active. Every drawn point carries its frame-buffer byte
// offset y * row_bytes + x * bytes_per_pixel; points outside the image are marked skipped
// and carry a zero offset. The block returns one result per request and sustains one
// request per clock while the output is not stalled. A request passes a two-entry queue, the
// line walker (one Bresenham step per clock unless stalled, set by the single error-term
// update) and two offset stages (multiply, then add). Configuration registers are written by
// index on cfg_write; the user must write them only while the block is idle (not enforced).
module bresenham_line_pixel_generator import bres_pkg::*; #(
  parameter int COORD_MAX   = 4096,
  parameter int OFFSET_BITS = 26,
  localparam int CW         = $clog2(COORD_MAX) + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   mode,
  input  logic [CW-1:0]          start_x,
  input  logic [CW-1:0]          start_y,
  input  logic [CW-1:0]          end_x,
  input  logic [CW-1:0]          end_y,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             status,
  output logic [OFFSET_BITS-1:0] pixel_offset,
  output logic [CW-1:0]          pixel_x,
  output logic [CW-1:0]          pixel_y,
  output logic                   last
);

  localparam int QW = KIND_W + 2 + 6 * CW;

  logic [DIM_W-1:0]  image_width, image_height;
  logic [ROWB_W-1:0] row_bytes;
  logic [BPP_W-1:0]  bytes_per_pixel;

  logic          q_push, q_full, q_pop, q_valid;
  logic [QW-1:0] q_in, q_out;

  logic          m_ready, p_valid;
  pt_ctl_t       p_ctl;
  logic [CW-1:0] p_x, p_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= RST_IMAGE_WIDTH;
      image_height    <= RST_IMAGE_HEIGHT;
      row_bytes       <= RST_ROW_BYTES;
      bytes_per_pixel <= RST_BYTES_PER_PIXEL;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:     image_width     <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    image_height    <= cfg_data[DIM_W-1:0];
        REG_ROW_BYTES:       row_bytes       <= cfg_data[ROWB_W-1:0];
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[BPP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bres_front #(.CW(CW), .QW(QW)) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .image_width  (image_width),
    .image_height (image_height),
    .q_push       (q_push),
    .q_data       (q_in),
    .q_full       (q_full)
  );

  bres_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .din       (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .dout      (q_out),
    .not_empty (q_valid)
  );

  bres_walk #(.CW(CW), .QW(QW)) u_walk (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .down_ready (m_ready),
    .p_valid    (p_valid),
    .p_ctl      (p_ctl),
    .p_x        (p_x),
    .p_y        (p_y)
  );

  bres_addr #(.CW(CW), .OB(OFFSET_BITS)) u_addr (
    .clk             (clk),
    .rst             (rst),
    .p_valid         (p_valid),
    .p_ctl           (p_ctl),
    .p_x             (p_x),
    .p_y             (p_y),
    .m_ready         (m_ready),
    .image_width     (image_width),
    .image_height    (image_height),
    .row_bytes       (row_bytes),
    .bytes_per_pixel (bytes_per_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .pixel_offset    (pixel_offset),
    .pixel_x         (pixel_x),
    .pixel_y         (pixel_y),
    .last            (last)
  );

endmodule

FILE: rtl/bres_checker.sv
// Port-level checks for the line pixel generator, bound to the top level.
module bres_checker import bres_pkg::*; #(
  parameter int COORD_MAX   = 4096,
  parameter int OFFSET_BITS = 26,
  localparam int CW         = $clog2(COORD_MAX) + 1
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [1:0]             status,
  input logic [OFFSET_BITS-1:0] pixel_offset,
  input logic [CW-1:0]          pixel_x,
  input logic [CW-1:0]          pixel_y,
  input logic                   last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(pixel_offset)
      && $stable(pixel_x) && $stable(pixel_y) && $stable(last))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DRAW) |-> pixel_offset == '0)
    else $error("offset set on a result that is not drawn");

  a_plain_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_REJECT || status == ST_IDLE)
      |-> pixel_x == '0 && pixel_y == '0 && !last)
    else $error("rejected or idle result carries a point");

endmodule

bind bresenham_line_pixel_generator bres_checker #(
  .COORD_MAX   (COORD_MAX),
  .OFFSET_BITS (OFFSET_BITS)
) u_bres_checker (.*);
